>>> hw/rtl/keeloq_cipher_half_key_macros.svh
// Assertion macros for the KeeLoq half-key cipher top level.
`ifndef KEELOQ_CIPHER_HALF_KEY_MACROS_SVH
`define KEELOQ_CIPHER_HALF_KEY_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KLQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KLQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/klq_pkg.sv
// Package: constants, types and round functions of the KeeLoq half-key cipher.
`timescale 1ns / 1ps
package klq_pkg;

  localparam int          KlqRounds   = 528;
  localparam logic [31:0] KlqNlf      = 32'h3A5C742E;
  localparam int          KlqKeyMask  = 63;
  localparam int          KlqDecStart = 15;

  typedef enum logic {
    KLQ_CMD_ENC = 1'b0,
    KLQ_CMD_DEC = 1'b1
  } klq_cmd_e;

  // Word that travels down the pipeline with its operation
  typedef struct packed {
    logic        command;
    logic [31:0] data_word;
  } klq_word_t;

  // Nonlinear function lookup
  function automatic logic klq_nlf(input logic [4:0] idx);
    return KlqNlf[idx];
  endfunction

  // One encryption round: shift right, feedback into the top bit
  function automatic logic [31:0] klq_enc_round(input logic [31:0] x, input logic kb);
    logic [4:0] idx;
    logic       fb;
    idx = {x[31], x[26], x[20], x[9], x[1]};
    fb  = x[0] ^ x[16] ^ klq_nlf(idx) ^ kb;
    return {fb, x[31:1]};
  endfunction

  // One decryption round: shift left, feedback into the bottom bit
  function automatic logic [31:0] klq_dec_round(input logic [31:0] x, input logic kb);
    logic [4:0] idx;
    logic       fb;
    idx = {x[30], x[25], x[19], x[8], x[0]};
    fb  = x[31] ^ x[15] ^ klq_nlf(idx) ^ kb;
    return {x[30:0], fb};
  endfunction

endpackage

>>> hw/rtl/klq_req_if.sv
// Request channel interface: operation and data word.
`timescale 1ns / 1ps
interface klq_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] data_word;

  modport source (output valid, output command, output data_word, input ready);
  modport sink   (input valid, input command, input data_word, output ready);
endinterface

>>> hw/rtl/klq_rsp_if.sv
// Response channel interface: transformed word.
`timescale 1ns / 1ps
interface klq_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_word;

  modport source (output valid, output result_word, input ready);
  modport sink   (input valid, input result_word, output ready);
endinterface

>>> hw/rtl/klq_cfg_if.sv
// Configuration write channel interface: half-key write data.
`timescale 1ns / 1ps
interface klq_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_half;

  modport source (output valid, output key_half, input ready);
  modport sink   (input valid, input key_half, output ready);
endinterface

>>> hw/rtl/keeloq_cipher_half_key.sv
// Top level: KeeLoq cipher, 528 rounds, 64-bit key made of one repeated 32-bit half key.
// Throughput: one request per cycle while the response side is ready;
// each stage register holds one word in flight.
// Backpressure ripples stage by stage, so empty stages fill even while the output waits.
// Reset clears all stage valid bits and the key register to zero.
`timescale 1ns / 1ps
`include "keeloq_cipher_half_key_macros.svh"
module keeloq_cipher_half_key #(
  parameter int ROUNDS_PER_STAGE = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  klq_cfg_if.sink  cfg_i,
  klq_req_if.sink  req_i,
  klq_rsp_if.source rsp_o
);
  import klq_pkg::*;

  localparam int NumStages = (KlqRounds + ROUNDS_PER_STAGE - 1) / ROUNDS_PER_STAGE;

  logic [31:0]    key;
  logic           stage_valid [NumStages+1];
  logic           stage_ready [NumStages+1];
  klq_word_t      stage_word  [NumStages+1];
  logic [NumStages-1:0] occupied;

  // Key register
  klq_key_reg u_key (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .key_o  (key)
  );

  // Feed the first stage from the request channel
  assign stage_valid[0]          = req_i.valid;
  assign stage_word[0].command   = req_i.command;
  assign stage_word[0].data_word = req_i.data_word;
  assign req_i.ready             = stage_ready[0];

  // Chain of round stages
  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    localparam int First = s * ROUNDS_PER_STAGE;
    localparam int Count = ((KlqRounds - First) < ROUNDS_PER_STAGE)
                           ? (KlqRounds - First) : ROUNDS_PER_STAGE;
    klq_round_stage #(
      .FirstRound (First),
      .NumRounds  (Count)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key),
      .valid_i (stage_valid[s]),
      .ready_o (stage_ready[s]),
      .word_i  (stage_word[s]),
      .valid_o (stage_valid[s+1]),
      .ready_i (stage_ready[s+1]),
      .word_o  (stage_word[s+1])
    );
    assign occupied[s] = stage_valid[s+1];
  end

  // Drive the response channel from the last stage
  assign rsp_o.valid            = stage_valid[NumStages];
  assign rsp_o.result_word      = stage_word[NumStages].data_word;
  assign stage_ready[NumStages] = rsp_o.ready;

  // A ready output lets the whole pipeline advance
  `KLQ_ASSERT_IMPL(a_out_ready_frees_in, clk_i, rst_ni, rsp_o.ready, req_i.ready,
    "request refused while response side is ready")

  // Refusing a request means every stage is full
  `KLQ_ASSERT_IMPL(a_full_when_stalled, clk_i, rst_ni, !req_i.ready, &occupied,
    "request refused with an empty stage")

  // An accepted request lands in the first stage
  `KLQ_ASSERT_NEXT(a_accept_fills_first, clk_i, rst_ni, req_i.valid && req_i.ready,
    occupied[0], "accepted request missing from first stage")

endmodule

>>> hw/rtl/klq_key_reg.sv
// Half-key configuration register.
`timescale 1ns / 1ps
module klq_key_reg (
  input  logic        clk_i,
  input  logic        rst_ni,
  klq_cfg_if.sink     cfg_i,
  output logic [31:0] key_o
);

  logic [31:0] key_d;
  logic [31:0] key_q;

  // Always take a write request
  assign cfg_i.ready = 1'b1;

  // Load new key on a write
  always_comb begin
    key_d = key_q;
    if (cfg_i.valid) begin
      key_d = cfg_i.key_half;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

>>> hw/rtl/klq_round_stage.sv
// One pipeline stage: a fixed group of cipher rounds and its output register.
`timescale 1ns / 1ps
module klq_round_stage #(
  parameter int FirstRound = 0,
  parameter int NumRounds  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         key_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  klq_pkg::klq_word_t  word_i,
  output logic                valid_o,
  input  logic                ready_i,
  output klq_pkg::klq_word_t  word_o
);
  import klq_pkg::*;

  logic [NumRounds:0][31:0] chain;
  logic                     dec;
  klq_word_t                word_d;
  klq_word_t                word_q;
  logic                     valid_d;
  logic                     valid_q;

  assign dec      = (word_i.command == KLQ_CMD_DEC);
  assign chain[0] = word_i.data_word;

  // Unroll this stage's rounds; key bit positions are fixed per round
  for (genvar j = 0; j < NumRounds; j++) begin : g_round
    localparam int         Rnd    = FirstRound + j;
    localparam logic [4:0] EncIdx = 5'((Rnd & KlqKeyMask) % 32);
    localparam logic [4:0] DecIdx = 5'(((KlqDecStart - Rnd) & KlqKeyMask) % 32);
    assign chain[j+1] = dec ? klq_dec_round(chain[j], key_i[DecIdx])
                            : klq_enc_round(chain[j], key_i[EncIdx]);
  end

  // Advance when empty or when the next stage takes our word
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d          = valid_q;
    word_d           = word_q;
    if (ready_o) begin
      valid_d          = valid_i;
      word_d.command   = word_i.command;
      word_d.data_word = chain[NumRounds];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload holds while stalled
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule
